// File: src/assert_macros.svh
// Assertion shorthands for the touch point filter blocks.
// Included by every module that carries concurrent checks; needs i_clk and i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, muted while reset is asserted.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked check that also holds across reset.
`define ASSERT_CLK_NR(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// File: src/tpfh_pkg.sv
// Shared types and constants for the touch point filter and hold unit.
// No dependencies; imported by every module of the block.
package tpfh_pkg;

    localparam int ADC_BITS   = 12;
    localparam int SCR_W      = 320;
    localparam int SCR_H      = 240;
    localparam int X_W        = 9;
    localparam int Y_W        = 8;
    localparam int COORD_W    = 9;                      // quotient width, covers both axes
    localparam int NUM_W      = ADC_BITS + COORD_W;     // |v - start| * size
    localparam int DCNT_W     = $clog2(COORD_W);
    localparam int THR_W      = 8;
    localparam int RUN_W      = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    // reciprocal of ten, exact for 12-bit inputs
    localparam int RECIP10_W  = 13;
    localparam int RECIP10_SH = 16;
    localparam int Q10_W      = 9;
    localparam logic [RECIP10_W-1:0] RECIP10 = 13'd6554;

    localparam logic [COORD_W-1:0] SIZE_X = COORD_W'(SCR_W);
    localparam logic [COORD_W-1:0] SIZE_Y = COORD_W'(SCR_H);
    localparam logic [RUN_W-1:0]   RUN_MAX = '1;

    // register map
    localparam logic [CFG_IDX_W-1:0] CFG_X_START  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_X_END    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_START  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_END    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPREAD   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_THR = 3'd5;

    localparam logic [ADC_BITS-1:0] RST_X_START  = 12'd180;
    localparam logic [ADC_BITS-1:0] RST_X_END    = 12'd3900;
    localparam logic [ADC_BITS-1:0] RST_Y_START  = 12'd260;
    localparam logic [ADC_BITS-1:0] RST_Y_END    = 12'd3700;
    localparam logic [ADC_BITS-1:0] RST_SPREAD   = 12'd2;
    localparam logic [THR_W-1:0]    RST_HOLD_THR = 8'd10;

    typedef struct packed {
        logic                pen_down;
        logic [ADC_BITS-1:0] x_sample_0;
        logic [ADC_BITS-1:0] x_sample_1;
        logic [ADC_BITS-1:0] x_sample_2;
        logic [ADC_BITS-1:0] x_sample_3;
        logic [ADC_BITS-1:0] y_sample_0;
        logic [ADC_BITS-1:0] y_sample_1;
        logic [ADC_BITS-1:0] y_sample_2;
        logic [ADC_BITS-1:0] y_sample_3;
    } t_in_word;

    typedef struct packed {
        logic           touched;
        logic           idle;
        logic           hold;
        logic           point_updated;
        logic [X_W-1:0] screen_x;
        logic [Y_W-1:0] screen_y;
    } t_out_word;

    typedef enum logic {AX_X, AX_Y} t_axis;

    typedef enum logic [2:0] {
        ST_IDLE, ST_FILT, ST_RECIP, ST_TRUNC, ST_SCALE, ST_DIV_GO, ST_DIV_WAIT, ST_COMMIT
    } t_state;

    typedef struct packed {
        logic  load;
        logic  filt;
        logic  recip;
        logic  trunc;
        logic  scale;
        logic  div_start;
        logic  commit;
        t_axis axis;
    } t_dp_cmd;

    typedef struct packed {
        logic pen;
        logic pass;
        logic div_done;
    } t_dp_sts;

endpackage

// File: src/tpfh_div.sv
// Restoring divider for the pixel scaling, one quotient bit per cycle.
// Depends on tpfh_pkg and assert_macros.svh.
`include "assert_macros.svh"

module tpfh_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [tpfh_pkg::NUM_W-1:0]   i_num,
    input  logic [tpfh_pkg::NUM_W-1:0]   i_lim,
    input  logic [tpfh_pkg::ADC_BITS-1:0] i_den,
    input  logic                         i_zero,
    input  logic [tpfh_pkg::COORD_W-1:0] i_sat,
    output logic                         o_done,
    output logic [tpfh_pkg::COORD_W-1:0] o_quo
);
    import tpfh_pkg::*;

    logic               r_busy, n_busy;
    logic               r_done, n_done;
    logic [NUM_W-1:0]   r_rem, n_rem;
    logic [NUM_W-1:0]   r_dsh, n_dsh;
    logic [COORD_W-1:0] r_quo, n_quo;
    logic [COORD_W-1:0] r_sat, n_sat;
    logic [DCNT_W-1:0]  r_cnt, n_cnt;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_rem  = r_rem;
        n_dsh  = r_dsh;
        n_quo  = r_quo;
        n_sat  = r_sat;
        n_cnt  = r_cnt;
        if (i_start) begin
            n_sat = i_sat;
            if (i_zero) begin
                // flat calibration, or sign puts the point before the start edge
                n_quo  = '0;
                n_done = 1'b1;
            end else if (i_num >= i_lim) begin
                n_quo  = i_sat;
                n_done = 1'b1;
            end else begin
                // quotient fits COORD_W bits here
                n_busy = 1'b1;
                n_rem  = i_num;
                n_dsh  = NUM_W'(i_den) << (COORD_W - 1);
                n_cnt  = DCNT_W'(COORD_W - 1);
                n_quo  = '0;
            end
        end else if (r_busy) begin
            if (r_rem >= r_dsh) begin
                n_rem = r_rem - r_dsh;
                n_quo = {r_quo[COORD_W-2:0], 1'b1};
            end else begin
                n_quo = {r_quo[COORD_W-2:0], 1'b0};
            end
            n_dsh = r_dsh >> 1;
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_dsh <= n_dsh;
        r_quo <= n_quo;
        r_sat <= n_sat;
        r_cnt <= n_cnt;
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

    `ASSERT_CLK(a_div_start_idle, i_start |-> !r_busy, "divider started while busy")
    `ASSERT_CLK(a_div_done_pulse, r_done |=> !r_done, "divider done held over two cycles")
    `ASSERT_CLK(a_div_quo_range, r_done |-> (r_quo <= r_sat), "quotient beyond screen edge")
    `ASSERT_CLK_NR(a_div_rst, !i_rst_n |=> (!r_done && !r_busy), "divider active after reset")

endmodule

// File: src/tpfh_ctrl.sv
// Sequencer for one touch update: filter, scale and divide per axis, then commit.
// Depends on tpfh_pkg and assert_macros.svh.
`include "assert_macros.svh"

module tpfh_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output tpfh_pkg::t_dp_cmd o_cmd,
    input  tpfh_pkg::t_dp_sts i_sts
);
    import tpfh_pkg::*;

    t_state r_state, n_state;
    t_axis  r_axis, n_axis;
    logic   r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_axis      <= AX_X;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_axis      <= n_axis;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_axis      = r_axis;
        n_out_valid = r_out_valid && i_out_stall;
        o_cmd       = '0;
        o_cmd.axis  = r_axis;
        o_in_stall  = (r_state != ST_IDLE);
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_axis     = AX_X;
                    n_state    = ST_FILT;
                end
            end
            ST_FILT: begin
                if (!i_sts.pen) begin
                    n_state = ST_COMMIT;
                end else begin
                    o_cmd.filt = 1'b1;
                    n_state    = ST_RECIP;
                end
            end
            ST_RECIP: begin
                // a rejected axis ends the point update
                if (!i_sts.pass) begin
                    n_state = ST_COMMIT;
                end else begin
                    o_cmd.recip = 1'b1;
                    n_state     = ST_TRUNC;
                end
            end
            ST_TRUNC: begin
                o_cmd.trunc = 1'b1;
                n_state     = ST_SCALE;
            end
            ST_SCALE: begin
                o_cmd.scale = 1'b1;
                n_state     = ST_DIV_GO;
            end
            ST_DIV_GO: begin
                o_cmd.div_start = 1'b1;
                n_state         = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (i_sts.div_done) begin
                    if (r_axis == AX_X) begin
                        n_axis  = AX_Y;
                        n_state = ST_FILT;
                    end else begin
                        n_state = ST_COMMIT;
                    end
                end
            end
            ST_COMMIT: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.commit = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_out_valid = r_out_valid;

    `ASSERT_CLK(a_commit_free, o_cmd.commit |-> !(r_out_valid && i_out_stall), "commit over held word")
    `ASSERT_CLK(a_out_from_commit, $rose(r_out_valid) |-> $past(o_cmd.commit), "word without commit")
    `ASSERT_CLK(a_done_in_wait, i_sts.div_done |-> (r_state == ST_DIV_WAIT), "stray divider done")

endmodule

// File: src/tpfh_dp.sv
// Datapath: config registers, sort and spread filter, rounding, scaling, hold tracking.
// Depends on tpfh_pkg and tpfh_div.
module tpfh_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  tpfh_pkg::t_in_word              i_in_word,
    input  logic                            i_cfg_we,
    input  logic [tpfh_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [tpfh_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  tpfh_pkg::t_dp_cmd               i_cmd,
    output tpfh_pkg::t_dp_sts               o_sts,
    output tpfh_pkg::t_out_word             o_out_word
);
    import tpfh_pkg::*;

    // config
    logic [ADC_BITS-1:0] r_x_start, r_x_end, r_y_start, r_y_end, r_spread;
    logic [THR_W-1:0]    r_hold_thr;

    // per-item work registers
    t_in_word            r_in;
    logic                r_pass;
    logic [ADC_BITS-1:0] r_avg;
    logic [Q10_W-1:0]    r_q10;
    logic [ADC_BITS-1:0] r_val;
    logic [NUM_W-1:0]    r_num, r_lim;
    logic [ADC_BITS-1:0] r_den;
    logic                r_zero;
    logic [X_W-1:0]      r_new_x;
    logic [Y_W-1:0]      r_new_y;

    // tracked state
    logic                r_last;
    logic [RUN_W-1:0]    r_run, n_run;
    logic                r_hold, n_hold;
    logic [X_W-1:0]      r_stored_x;
    logic [Y_W-1:0]      r_stored_y;
    t_out_word           r_out_word, n_out_word;

    logic [ADC_BITS-1:0] s0, s1, s2, s3;
    logic [ADC_BITS-1:0] l0, h0, l1, h1, m1, m2;
    logic [ADC_BITS-1:0] srt0, srt1, srt2, srt3;
    logic                pass;
    logic [ADC_BITS:0]   mid_sum;
    logic [ADC_BITS+RECIP10_W-1:0] recip_prod;
    logic [ADC_BITS-1:0] trunc_val;
    logic [ADC_BITS-1:0] cal_start, cal_end;
    logic [COORD_W-1:0]  size, sat;
    logic signed [ADC_BITS:0] diff, span;
    logic [ADC_BITS-1:0] abs_diff, abs_span;
    logic [NUM_W-1:0]    num, lim;
    logic                zero;
    logic                div_done;
    logic [COORD_W-1:0]  div_quo;
    logic                pen, idle, updated;

    // -------- sort network and spread test --------
    always_comb begin
        if (i_cmd.axis == AX_X) begin
            s0 = r_in.x_sample_0;
            s1 = r_in.x_sample_1;
            s2 = r_in.x_sample_2;
            s3 = r_in.x_sample_3;
        end else begin
            s0 = r_in.y_sample_0;
            s1 = r_in.y_sample_1;
            s2 = r_in.y_sample_2;
            s3 = r_in.y_sample_3;
        end
        l0   = (s0 <= s1) ? s0 : s1;
        h0   = (s0 <= s1) ? s1 : s0;
        l1   = (s2 <= s3) ? s2 : s3;
        h1   = (s2 <= s3) ? s3 : s2;
        srt0 = (l0 <= l1) ? l0 : l1;
        m1   = (l0 <= l1) ? l1 : l0;
        m2   = (h0 <= h1) ? h0 : h1;
        srt3 = (h0 <= h1) ? h1 : h0;
        srt1 = (m1 <= m2) ? m1 : m2;
        srt2 = (m1 <= m2) ? m2 : m1;
        pass = ((srt1 - srt0) < r_spread) && ((srt2 - srt1) < r_spread)
            && ((srt3 - srt2) < r_spread);
        mid_sum = {1'b0, srt1} + {1'b0, srt2};
    end

    // -------- round down to a multiple of ten --------
    assign recip_prod = r_avg * RECIP10;
    assign trunc_val  = {r_q10, 3'b000} + ADC_BITS'({r_q10, 1'b0});

    // -------- scale setup --------
    always_comb begin
        if (i_cmd.axis == AX_X) begin
            cal_start = r_x_start;
            cal_end   = r_x_end;
            size      = SIZE_X;
        end else begin
            cal_start = r_y_start;
            cal_end   = r_y_end;
            size      = SIZE_Y;
        end
        sat      = size - 1'b1;
        diff     = $signed({1'b0, r_val}) - $signed({1'b0, cal_start});
        span     = $signed({1'b0, cal_end}) - $signed({1'b0, cal_start});
        abs_diff = diff[ADC_BITS] ? ADC_BITS'(-diff) : diff[ADC_BITS-1:0];
        abs_span = span[ADC_BITS] ? ADC_BITS'(-span) : span[ADC_BITS-1:0];
        num      = NUM_W'(abs_diff) * NUM_W'(size);
        lim      = NUM_W'(abs_span) * NUM_W'(size);
        // opposite signs floor to a negative value, which clamps to zero
        zero     = (span == '0) || ((diff != '0) && (diff[ADC_BITS] != span[ADC_BITS]));
    end

    tpfh_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (r_num),
        .i_lim   (r_lim),
        .i_den   (r_den),
        .i_zero  (r_zero),
        .i_sat   (sat),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    // -------- press run, hold and output word --------
    always_comb begin
        pen     = r_in.pen_down;
        idle    = !pen && !r_last;
        updated = pen && r_pass;
        if (!pen) begin
            n_run = '0;
        end else if (r_last && (r_run != RUN_MAX)) begin
            n_run = r_run + 1'b1;
        end else begin
            n_run = r_run;
        end
        n_hold = (pen && r_hold) || (n_run >= r_hold_thr);
        n_out_word.touched       = pen;
        n_out_word.idle          = idle;
        n_out_word.hold          = idle ? r_hold : n_hold;
        n_out_word.point_updated = updated;
        n_out_word.screen_x      = updated ? r_new_x : r_stored_x;
        n_out_word.screen_y      = updated ? r_new_y : r_stored_y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_start  <= RST_X_START;
            r_x_end    <= RST_X_END;
            r_y_start  <= RST_Y_START;
            r_y_end    <= RST_Y_END;
            r_spread   <= RST_SPREAD;
            r_hold_thr <= RST_HOLD_THR;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_X_START:  r_x_start  <= i_cfg_data;
                CFG_X_END:    r_x_end    <= i_cfg_data;
                CFG_Y_START:  r_y_start  <= i_cfg_data;
                CFG_Y_END:    r_y_end    <= i_cfg_data;
                CFG_SPREAD:   r_spread   <= i_cfg_data;
                CFG_HOLD_THR: r_hold_thr <= i_cfg_data[THR_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last     <= 1'b0;
            r_run      <= '0;
            r_hold     <= 1'b0;
            r_stored_x <= '0;
            r_stored_y <= '0;
            r_pass     <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_pass <= 1'b0;
            end else if (i_cmd.filt) begin
                r_pass <= pass;
            end
            if (i_cmd.commit && !idle) begin
                r_last <= pen;
                r_run  <= n_run;
                r_hold <= n_hold;
                if (updated) begin
                    r_stored_x <= r_new_x;
                    r_stored_y <= r_new_y;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_in <= i_in_word;
        end
        if (i_cmd.filt) begin
            r_avg <= mid_sum[ADC_BITS:1];
        end
        if (i_cmd.recip) begin
            r_q10 <= recip_prod[RECIP10_SH +: Q10_W];
        end
        if (i_cmd.trunc) begin
            r_val <= trunc_val;
        end
        if (i_cmd.scale) begin
            r_num  <= num;
            r_lim  <= lim;
            r_den  <= abs_span;
            r_zero <= zero;
        end
        if (div_done) begin
            case (i_cmd.axis)
                AX_X:    r_new_x <= div_quo[X_W-1:0];
                AX_Y:    r_new_y <= div_quo[Y_W-1:0];
                default: ;
            endcase
        end
        if (i_cmd.commit) begin
            r_out_word <= n_out_word;
        end
    end

    assign o_sts.pen      = r_in.pen_down;
    assign o_sts.pass     = r_pass;
    assign o_sts.div_done = div_done;
    assign o_out_word     = r_out_word;

endmodule

// File: src/touch_point_filter_and_hold_unit.sv
// Touch point filter and hold unit, top level. Uses tpfh_pkg, tpfh_ctrl, tpfh_dp.
// With the pen up a word goes from capture through the pen check to commit; pressed, each
// axis passes sort, reciprocal, truncate, scale, divider start, up to 9 divider steps, done.
// One word is in flight at a time: the next word is taken once the controller is back in
// idle after the commit, and a result still held by a stall delays the commit.
// Reset (sync, active low) loads calibration defaults and clears point and hold state.
module touch_point_filter_and_hold_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // input words: pen flag and four raw samples per axis
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  tpfh_pkg::t_in_word              i_in_word,
    // result words
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output tpfh_pkg::t_out_word             o_out_word,
    // register writes, only while no update is in flight
    input  logic                            i_cfg_we,
    input  logic [tpfh_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [tpfh_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import tpfh_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    // Controller walks each word through: capture, sort/spread check, reciprocal
    // multiply, multiple-of-ten truncation, calibration scaling, divide. X first,
    // then Y; a rejected axis or a released pen jumps straight to commit.
    tpfh_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    // Datapath owns the registers, stored point, press run and the output word
    // register; the output register lets a new word start while the last result waits.
    tpfh_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_word  (i_in_word),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_out_word (o_out_word)
    );

endmodule

// File: tb/touch_point_filter_and_hold_unit_test.sv
// Self-checking bench for touch_point_filter_and_hold_unit: directed table, then random press runs.
// Needs tpfh_pkg and the unit's RTL; predicts every result word with its own model of the filter.
module touch_point_filter_and_hold_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import tpfh_pkg::*;

    // Cycle budget: about 1100 words, plus random gaps and stalls.
    localparam int CYCLE_LIMIT = 500000;
    localparam int DIR_ROWS    = 16;
    localparam int END_WAIT    = 40;

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  in_valid   = 1'b0;
    logic                  in_stall;
    t_in_word              in_word    = '0;
    logic                  out_valid;
    logic                  out_stall  = 1'b0;
    t_out_word             out_word;
    logic                  cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx    = '0;
    logic [CFG_DATA_W-1:0] cfg_data   = '0;

    // no idling on either side while set
    logic quiet = 1'b0;

    int        cycle_count    = 0;
    int        mismatch_count = 0;
    t_out_word expected_updates [$];

    // predictor copy of calibration registers
    logic [ADC_BITS-1:0] cal_x_start = RST_X_START;
    logic [ADC_BITS-1:0] cal_x_end   = RST_X_END;
    logic [ADC_BITS-1:0] cal_y_start = RST_Y_START;
    logic [ADC_BITS-1:0] cal_y_end   = RST_Y_END;
    logic [ADC_BITS-1:0] spread_lim  = RST_SPREAD;
    logic [THR_W-1:0]    hold_thr    = RST_HOLD_THR;

    // predictor copy of tracker state
    logic             prev_pressed = 1'b0;
    logic [RUN_W-1:0] run_len      = '0;
    logic             hold_state   = 1'b0;
    logic [X_W-1:0]   point_x      = '0;
    logic [Y_W-1:0]   point_y      = '0;

    touch_point_filter_and_hold_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Directed table. Rows with has_want set carry a typed result word:
    // idle after reset, all-zero and all-max samples, and a spread reject.
    // The rest are checked against the predictor. Defaults: x 180..3900,
    // y 260..3700, spread 2, hold after a run of 10.
    // ------------------------------------------------------------------
    typedef struct {
        bit        has_want;
        t_in_word  word;
        t_out_word want;
    } t_dir_row;

    t_dir_row dir_rows [DIR_ROWS] = '{
        // pen up after reset: idle, nothing stored
        '{1'b1, '{1'b0, 12'h000, 12'h000, 12'h000, 12'h000, 12'h000, 12'h000, 12'h000, 12'h000},
              '{1'b0, 1'b1, 1'b0, 1'b0, 9'd0, 8'd0}},
        '{1'b1, '{1'b0, 12'hfff, 12'hfff, 12'hfff, 12'hfff, 12'hfff, 12'hfff, 12'hfff, 12'hfff},
              '{1'b0, 1'b1, 1'b0, 1'b0, 9'd0, 8'd0}},
        // all zero: below start on both axes, clamps to 0
        '{1'b1, '{1'b1, 12'h000, 12'h000, 12'h000, 12'h000, 12'h000, 12'h000, 12'h000, 12'h000},
              '{1'b1, 1'b0, 1'b0, 1'b1, 9'd0, 8'd0}},
        // all max: past end, clamps to the far corner
        '{1'b1, '{1'b1, 12'hfff, 12'hfff, 12'hfff, 12'hfff, 12'hfff, 12'hfff, 12'hfff, 12'hfff},
              '{1'b1, 1'b0, 1'b0, 1'b1, 9'd319, 8'd239}},
        // wide X spread: rejected, point kept
        '{1'b1, '{1'b1, 12'h000, 12'hfff, 12'h000, 12'hfff, 12'd800, 12'd800, 12'd800, 12'd800},
              '{1'b1, 1'b0, 1'b0, 1'b0, 9'd319, 8'd239}},
        // X unsorted but tight, Y gap of exactly the limit
        '{1'b0, '{1'b1, 12'd2043, 12'd2041, 12'd2042, 12'd2040, 12'd100, 12'd102, 12'd101, 12'd104},
              '0},
        '{1'b0, '{1'b1, 12'd1000, 12'd1000, 12'd1000, 12'd1000, 12'h555, 12'h556, 12'h555, 12'h556},
              '0},
        '{1'b0, '{1'b1, 12'haaa, 12'haaa, 12'haab, 12'haaa, 12'h2aa, 12'h2aa, 12'h2ab, 12'h2ab},
              '0},
        // exactly on the start values
        '{1'b0, '{1'b1, 12'd180, 12'd180, 12'd180, 12'd180, 12'd260, 12'd260, 12'd260, 12'd260},
              '0},
        // exactly on the end values
        '{1'b0, '{1'b1, 12'd3900, 12'd3900, 12'd3900, 12'd3900, 12'd3700, 12'd3700, 12'd3700, 12'd3700},
              '0},
        '{1'b0, '{1'b1, 12'd3899, 12'd3900, 12'd3899, 12'd3900, 12'd3699, 12'd3700, 12'd3700, 12'd3699},
              '0},
        '{1'b0, '{1'b1, 12'd179, 12'd179, 12'd180, 12'd180, 12'd259, 12'd260, 12'd259, 12'd260},
              '0},
        // run reaches the threshold here: hold goes high
        '{1'b0, '{1'b1, 12'd1234, 12'd1235, 12'd1234, 12'd1235, 12'd2345, 12'd2345, 12'd2346, 12'd2346},
              '0},
        '{1'b0, '{1'b1, 12'd3000, 12'd3001, 12'd3000, 12'd3000, 12'd600, 12'd600, 12'd601, 12'd601},
              '0},
        // release clears run and hold, then a true idle
        '{1'b0, '{1'b0, 12'h123, 12'h456, 12'h789, 12'habc, 12'hdef, 12'h012, 12'h345, 12'h678},
              '0},
        '{1'b0, '{1'b0, 12'h800, 12'h001, 12'h7fe, 12'hfff, 12'h000, 12'hc00, 12'h3ff, 12'h555},
              '0}
    };

    // Sorts one axis and applies the spread test; on a pass, val is the
    // mean of the middle pair rounded down to a multiple of ten.
    function automatic bit filter_axis(input logic [3:0][ADC_BITS-1:0] raw,
                                       output logic [ADC_BITS-1:0] val);
        int s [4];
        int tmp;
        int mid;
        for (int i = 0; i < 4; i++) s[i] = int'(raw[i]);
        for (int i = 0; i < 3; i++)
            for (int j = i + 1; j < 4; j++)
                if (s[i] > s[j]) begin
                    tmp  = s[i];
                    s[i] = s[j];
                    s[j] = tmp;
                end
        val = '0;
        for (int i = 0; i < 3; i++)
            if (s[i + 1] - s[i] >= int'(spread_lim)) return 1'b0;
        mid = (s[1] + s[2]) >> 1;
        val = ADC_BITS'(mid - (mid % 10));
        return 1'b1;
    endfunction

    // Floor of (v - start) * size / (stop - start), clamped to the screen.
    function automatic int scale_axis(int v, int start, int stop, int size);
        longint n;
        longint d;
        longint q;
        n = longint'(v - start) * longint'(size);
        d = longint'(stop - start);
        if (d == 0) return 0;
        q = n / d;
        if ((n % d) != 0 && ((n < 0) != (d < 0))) q = q - 1;
        if (q < 0) q = 0;
        if (q > size - 1) q = size - 1;
        return int'(q);
    endfunction

    // Advances the tracker by one update and returns the result word it implies.
    function automatic t_out_word predict_update(t_in_word w);
        t_out_word           r;
        logic [ADC_BITS-1:0] vx;
        logic [ADC_BITS-1:0] vy;
        bit                  ok_x;
        bit                  ok_y;
        bit                  idle_now;
        bit                  upd;
        idle_now = 1'b0;
        upd      = 1'b0;
        if (!w.pen_down && !prev_pressed) begin
            idle_now = 1'b1;        // nothing moves, not even hold
        end else begin
            if (!w.pen_down) begin
                run_len    = '0;
                hold_state = 1'b0;
            end else begin
                ok_x = filter_axis({w.x_sample_0, w.x_sample_1, w.x_sample_2, w.x_sample_3}, vx);
                ok_y = filter_axis({w.y_sample_0, w.y_sample_1, w.y_sample_2, w.y_sample_3}, vy);
                if (ok_x && ok_y) begin
                    point_x = X_W'(scale_axis(int'(vx), int'(cal_x_start), int'(cal_x_end), SCR_W));
                    point_y = Y_W'(scale_axis(int'(vy), int'(cal_y_start), int'(cal_y_end), SCR_H));
                    upd     = 1'b1;
                end
                if (prev_pressed && run_len != RUN_MAX) run_len = run_len + 1'b1;
            end
            // a zero threshold sets hold on releases too
            if (run_len >= hold_thr) hold_state = 1'b1;
            prev_pressed = w.pen_down;
        end
        r.touched       = w.pen_down;
        r.idle          = idle_now;
        r.hold          = hold_state;
        r.point_updated = upd;
        r.screen_x      = point_x;
        r.screen_y      = point_y;
        return r;
    endfunction

    // Four samples of one axis. Clean sets stay inside the spread limit;
    // noisy sets are fully random or a clean set with one outlier.
    function automatic logic [3:0][ADC_BITS-1:0] axis_samples(bit clean);
        logic [3:0][ADC_BITS-1:0] s;
        int kmax;
        int k;
        int base;
        kmax = (int'(spread_lim) > 301) ? 300 : ((spread_lim > 0) ? int'(spread_lim) - 1 : 0);
        k    = ($urandom_range(0, 3) == 0) ? $urandom_range(0, kmax)
                                           : $urandom_range(0, (kmax > 3) ? 3 : kmax);
        base = $urandom_range(0, 4095 - k);
        for (int i = 0; i < 4; i++) s[i] = ADC_BITS'(base + $urandom_range(0, k));
        if (!clean) begin
            if ($urandom_range(0, 1) == 0)
                for (int i = 0; i < 4; i++) s[i] = ADC_BITS'($urandom());
            else
                s[$urandom_range(0, 3)] = ADC_BITS'($urandom());
        end
        return s;
    endfunction

    function automatic t_in_word random_word(bit pen);
        t_in_word                 w;
        logic [3:0][ADC_BITS-1:0] xs;
        logic [3:0][ADC_BITS-1:0] ys;
        xs = axis_samples(pen ? ($urandom_range(0, 99) < 85) : 1'b0);
        ys = axis_samples(pen ? ($urandom_range(0, 99) < 85) : 1'b0);
        w.pen_down   = pen;
        w.x_sample_0 = xs[0];
        w.x_sample_1 = xs[1];
        w.x_sample_2 = xs[2];
        w.x_sample_3 = xs[3];
        w.y_sample_0 = ys[0];
        w.y_sample_1 = ys[1];
        w.y_sample_2 = ys[2];
        w.y_sample_3 = ys[3];
        return w;
    endfunction

    // Offers one word, waits for it to be taken, then queues its expected result.
    // in_valid is only lowered in a gap, so it never sees two updates in one step.
    task automatic push_word(input t_in_word w, input bit has_want, input t_out_word want);
        t_out_word pred;
        while (!quiet && $urandom_range(0, 99) < 30) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        pred = predict_update(w);
        expected_updates.push_back(has_want ? want : pred);
    endtask

    // cfg_we is left high between back-to-back writes; the caller drops it.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            CFG_X_START:  cal_x_start = data;
            CFG_X_END:    cal_x_end   = data;
            CFG_Y_START:  cal_y_start = data;
            CFG_Y_END:    cal_y_end   = data;
            CFG_SPREAD:   spread_lim  = data;
            CFG_HOLD_THR: hold_thr    = data[THR_W-1:0];
            default: ;
        endcase
    endtask

    task automatic drain;
        while (expected_updates.size() != 0) @(posedge i_clk);
    endtask

    // Every word yields a result, so an empty queue means the unit is idle.
    task automatic start_phase(input int xs, input int xe, input int ys, input int ye,
                               input int sp, input int thr, input bit q);
        in_valid <= 1'b0;
        drain();
        write_reg(CFG_X_START,  CFG_DATA_W'(xs));
        write_reg(CFG_X_END,    CFG_DATA_W'(xe));
        write_reg(CFG_Y_START,  CFG_DATA_W'(ys));
        write_reg(CFG_Y_END,    CFG_DATA_W'(ye));
        write_reg(CFG_SPREAD,   CFG_DATA_W'(sp));
        // upper data bits are junk the register must drop
        write_reg(CFG_HOLD_THR, {4'($urandom()), 8'(thr)});
        cfg_we <= 1'b0;
        quiet  <= q;
    endtask

    // Press runs of random length, each closed by a release and a few idle words.
    // A long first run pushes the run counter into saturation.
    task automatic random_phase(input int n_items, input bit long_first);
        int  done_items;
        int  press_len;
        int  idle_len;
        bit  first;
        done_items = 0;
        first      = long_first;
        while (done_items < n_items) begin
            if (first)
                press_len = 300;
            else if ($urandom_range(0, 9) == 0)
                press_len = $urandom_range(20, 60);
            else
                press_len = $urandom_range(1, 12);
            first    = 1'b0;
            idle_len = $urandom_range(0, 3);
            repeat (press_len) push_word(random_word(1'b1), 1'b0, '0);
            push_word(random_word(1'b0), 1'b0, '0);
            repeat (idle_len) push_word(random_word(1'b0), 1'b0, '0);
            done_items += press_len + 1 + idle_len;
        end
    endtask

    task automatic note_mismatch(input string field, input int want, input int got);
        mismatch_count++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    endtask

    // Result side: compare every accepted word with the oldest expectation.
    always @(posedge i_clk) begin
        t_out_word want;
        if (i_rst_n && out_valid && !out_stall) begin
            if (expected_updates.size() == 0) begin
                mismatch_count++;
                $display("%0t: result word with nothing expected, actual %h", $time, out_word);
            end else begin
                want = expected_updates.pop_front();
                if (out_word.touched != want.touched)
                    note_mismatch("touched", want.touched, out_word.touched);
                if (out_word.idle != want.idle)
                    note_mismatch("idle", want.idle, out_word.idle);
                if (out_word.hold != want.hold)
                    note_mismatch("hold", want.hold, out_word.hold);
                if (out_word.point_updated != want.point_updated)
                    note_mismatch("point_updated", want.point_updated, out_word.point_updated);
                if (out_word.screen_x != want.screen_x)
                    note_mismatch("screen_x", want.screen_x, out_word.screen_x);
                if (out_word.screen_y != want.screen_y)
                    note_mismatch("screen_y", want.screen_y, out_word.screen_y);
            end
        end
        out_stall <= quiet ? 1'b0 : ($urandom_range(0, 99) < 30);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // defaults from reset
        for (int r = 0; r < DIR_ROWS; r++)
            push_word(dir_rows[r].word, dir_rows[r].has_want, dir_rows[r].want);

        // full-scale window, widest spread, top threshold reached by a long press
        start_phase(0, 4095, 0, 4095, 4095, 255, 1'b0);
        random_phase(130, 1'b1);

        // reversed calibration, tightest spread, threshold of one; no idling at all
        start_phase(4095, 0, 3700, 260, 1, 1, 1'b1);
        random_phase(130, 1'b0);

        // degenerate calibration, zero spread rejects all, zero threshold holds always
        start_phase(2000, 2000, 0, 0, 0, 0, 1'b0);
        random_phase(60, 1'b0);

        // narrow window: most points saturate at an edge
        start_phase(2000, 2100, 1000, 1050, 8, 5, 1'b0);
        random_phase(130, 1'b0);

        repeat (5) begin
            start_phase($urandom_range(0, 4095), $urandom_range(0, 4095),
                        $urandom_range(0, 4095), $urandom_range(0, 4095),
                        $urandom_range(1, 200), $urandom_range(1, 40), 1'b0);
            random_phase(80, 1'b0);
        end

        in_valid <= 1'b0;
        drain();
        repeat (END_WAIT) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// File: files.f
+incdir+src
src/tpfh_pkg.sv
src/tpfh_div.sv
src/tpfh_ctrl.sv
src/tpfh_dp.sv
src/touch_point_filter_and_hold_unit.sv
tb/touch_point_filter_and_hold_unit_test.sv
